[rtl/urcd_pkg.sv]
// Shared types, constants and helpers for the UDP receive check and demux block.
`timescale 1ns / 1ps

package urcd_pkg;

    localparam int IN_TDATA_W  = 72;   // data_byte, src_ip, dst_ip
    localparam int OUT_TDATA_W = 56;   // verdict fields, padded to 7 bytes
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int SLOT_REGS   = 8;
    localparam int PORT_SLOTS  = 8;
    localparam int HDR_BYTES   = 8;
    localparam int MAX_PAYLOAD = 1500;

    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    typedef logic [2:0] t_reason;
    localparam t_reason RSN_OK      = 3'd0;
    localparam t_reason RSN_SHORT   = 3'd1;
    localparam t_reason RSN_BAD_LEN = 3'd2;
    localparam t_reason RSN_TOO_LONG = 3'd3;
    localparam t_reason RSN_CKSUM   = 3'd4;
    localparam t_reason RSN_NO_PORT = 3'd5;

    typedef logic [SLOT_REGS-1:0][15:0] t_slots;

    // Everything the verdict stage needs from one finished datagram.
    typedef struct packed {
        logic [16:0] total;     // bytes seen, saturated count plus one
        logic [15:0] len;
        logic [15:0] cksum;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] sum;       // datagram one's-complement sum
        logic [15:0] psum;      // pseudo-header one's-complement sum
        logic [7:0]  pend;      // unpaired high byte
    } t_snap;

    // 16-bit one's-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

[rtl/urcd_accum.sv]
// Input register and per-beat header capture / running checksum accumulation.
`timescale 1ns / 1ps

module urcd_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [urcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    input  logic                                i_snap_take,
    output logic                                o_snap_valid,
    output urcd_pkg::t_snap                     o_snap
);

    // input register
    logic        r_a_valid;
    logic [7:0]  r_a_byte;
    logic        r_a_last;
    logic [31:0] r_a_src;
    logic [31:0] r_a_dst;

    // running datagram state
    logic [15:0] r_cnt,   n_cnt;
    logic [15:0] r_sum,   n_sum;
    logic [15:0] r_psum,  n_psum;
    logic [7:0]  r_pend,  n_pend;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_cks,   n_cks;
    logic [15:0] r_sport, n_sport;
    logic [15:0] r_dport, n_dport;
    logic [63:0] r_addr,  n_addr;

    logic            r_s_valid;
    urcd_pkg::t_snap r_snap;

    logic        s_free;
    logic        a_go;
    logic        in_acc;
    logic        summed;
    logic [7:0]  v;
    logic [15:0] p_add;
    logic        p_en;

    assign s_free        = !r_s_valid || i_snap_take;
    assign a_go          = r_a_valid && (!r_a_last || s_free);
    assign s_axis_tready = !r_a_valid || a_go;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_addr  = r_addr;
        n_sport = r_sport;
        n_dport = r_dport;
        n_len   = r_len;
        n_cks   = r_cks;
        n_sum   = r_sum;
        n_pend  = r_pend;
        n_psum  = r_psum;
        p_add   = 16'd0;
        p_en    = 1'b0;

        if (r_cnt == 16'd0) begin
            n_addr = {r_a_src, r_a_dst};
        end

        if (r_cnt < 16'd2) begin
            n_sport = {r_sport[7:0], r_a_byte};
        end else if (r_cnt < 16'd4) begin
            n_dport = {r_dport[7:0], r_a_byte};
        end else if (r_cnt < 16'd6) begin
            n_len = {r_len[7:0], r_a_byte};
        end else if (r_cnt < 16'd8) begin
            n_cks = {r_cks[7:0], r_a_byte};
        end

        // checksum bytes enter the sum as zero
        summed = (r_cnt < 16'd8) || (r_cnt < r_len);
        v      = (r_cnt == 16'd6 || r_cnt == 16'd7) ? 8'd0 : r_a_byte;
        if (summed) begin
            if (!r_cnt[0]) begin
                n_pend = v;
            end else begin
                n_sum = urcd_pkg::oc_add(r_sum, {r_pend, v});
            end
        end

        // pseudo-header folded in over the header beats
        case (r_cnt)
            16'd1: begin p_add = r_addr[63:48]; p_en = 1'b1; end
            16'd2: begin p_add = r_addr[47:32]; p_en = 1'b1; end
            16'd3: begin p_add = r_addr[31:16]; p_en = 1'b1; end
            16'd4: begin p_add = r_addr[15:0];  p_en = 1'b1; end
            16'd5: begin p_add = urcd_pkg::PROTO_UDP; p_en = 1'b1; end
            16'd6: begin p_add = r_len; p_en = 1'b1; end
            default: begin p_add = 16'd0; p_en = 1'b0; end
        endcase
        if (p_en) begin
            n_psum = urcd_pkg::oc_add(r_psum, p_add);
        end

        n_cnt = (r_cnt != urcd_pkg::CNT_MAX) ? r_cnt + 16'd1 : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_byte <= s_axis_tdata[7:0];
            r_a_src  <= s_axis_tdata[39:8];
            r_a_dst  <= s_axis_tdata[71:40];
            r_a_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 16'd0;
            r_sum   <= 16'd0;
            r_psum  <= 16'd0;
            r_pend  <= 8'd0;
            r_len   <= 16'd0;
            r_cks   <= 16'd0;
            r_sport <= 16'd0;
            r_dport <= 16'd0;
            r_addr  <= 64'd0;
        end else if (a_go) begin
            r_addr <= n_addr;
            if (r_a_last) begin
                r_cnt   <= 16'd0;
                r_sum   <= 16'd0;
                r_psum  <= 16'd0;
                r_pend  <= 8'd0;
                r_len   <= 16'd0;
                r_cks   <= 16'd0;
                r_sport <= 16'd0;
                r_dport <= 16'd0;
            end else begin
                r_cnt   <= n_cnt;
                r_sum   <= n_sum;
                r_psum  <= n_psum;
                r_pend  <= n_pend;
                r_len   <= n_len;
                r_cks   <= n_cks;
                r_sport <= n_sport;
                r_dport <= n_dport;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (a_go && r_a_last) begin
            r_s_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_s_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go && r_a_last) begin
            r_snap.total <= {1'b0, r_cnt} + 17'd1;
            r_snap.len   <= n_len;
            r_snap.cksum <= n_cks;
            r_snap.sport <= n_sport;
            r_snap.dport <= n_dport;
            r_snap.sum   <= n_sum;
            r_snap.psum  <= n_psum;
            r_snap.pend  <= n_pend;
        end
    end

    assign o_snap_valid = r_s_valid;
    assign o_snap       = r_snap;

    // a finished snapshot is never overwritten before the verdict stage takes it
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid && !i_snap_take |=> r_s_valid && $stable(r_snap))
        else $error("snapshot lost before verdict");

    // every datagram restarts its byte count
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && r_a_last |=> r_cnt == 16'd0 && r_sum == 16'd0 && r_psum == 16'd0)
        else $error("datagram state not cleared");

    // the input stage only retires a last beat when the snapshot slot is free
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_go && r_a_last |-> s_free)
        else $error("last beat retired without snapshot slot");

endmodule

[rtl/urcd_verdict.sv]
// Length, checksum and port checks on a finished datagram, plus the result register.
`timescale 1ns / 1ps

module urcd_verdict (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_snap_valid,
    input  urcd_pkg::t_snap                     i_snap,
    input  urcd_pkg::t_slots                    i_slots,
    output logic                                o_snap_take,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [urcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    logic                r_o_valid;
    logic                r_acc;
    urcd_pkg::t_reason   r_rsn;
    logic [2:0]          r_ep;
    logic [15:0]         r_sport;
    logic [15:0]         r_dport;
    logic [15:0]         r_plen;

    logic                o_free;
    logic                acc;
    urcd_pkg::t_reason   rsn;
    logic [2:0]          ep;
    logic                hit;
    logic [2:0]          hit_ep;
    logic [15:0]         pad;
    logic [17:0]         t0;
    logic [16:0]         t1;
    logic [16:0]         t2;
    logic [15:0]         cks;
    logic                cks_ok;

    assign o_free      = !r_o_valid || m_axis_tready;
    assign o_snap_take = i_snap_valid && o_free;

    always_comb begin
        // pad an odd trailing byte with zero, then fold the three partial sums
        pad    = i_snap.len[0] ? {i_snap.pend, 8'd0} : 16'd0;
        t0     = {2'd0, i_snap.sum} + {2'd0, i_snap.psum} + {2'd0, pad};
        t1     = {1'b0, t0[15:0]} + {15'd0, t0[17:16]};
        t2     = {1'b0, t1[15:0]} + {16'd0, t1[16]};
        cks    = ~t2[15:0];
        cks_ok = (cks == i_snap.cksum) || (cks == 16'd0 && i_snap.cksum == 16'hFFFF);

        hit    = 1'b0;
        hit_ep = 3'd0;
        for (int i = urcd_pkg::PORT_SLOTS - 1; i >= 0; i--) begin
            if (i_slots[i] != 16'd0 && i_slots[i] == i_snap.dport) begin
                hit    = 1'b1;
                hit_ep = 3'(i);
            end
        end

        acc = 1'b0;
        ep  = 3'd0;
        if (i_snap.total < 17'(urcd_pkg::HDR_BYTES)) begin
            rsn = urcd_pkg::RSN_SHORT;
        end else if (i_snap.len < 16'(urcd_pkg::HDR_BYTES)
                     || {1'b0, i_snap.len} > i_snap.total) begin
            rsn = urcd_pkg::RSN_BAD_LEN;
        end else if (i_snap.cksum != 16'd0 && i_snap.len > 16'(urcd_pkg::MAX_PAYLOAD)) begin
            rsn = urcd_pkg::RSN_TOO_LONG;
        end else if (i_snap.cksum != 16'd0 && !cks_ok) begin
            rsn = urcd_pkg::RSN_CKSUM;
        end else if (hit) begin
            rsn = urcd_pkg::RSN_OK;
            acc = 1'b1;
            ep  = hit_ep;
        end else begin
            rsn = urcd_pkg::RSN_NO_PORT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_acc <= acc;
            r_rsn <= rsn;
            r_ep  <= ep;
            if (rsn == urcd_pkg::RSN_SHORT) begin
                r_sport <= 16'd0;
                r_dport <= 16'd0;
                r_plen  <= 16'd0;
            end else begin
                r_sport <= i_snap.sport;
                r_dport <= i_snap.dport;
                r_plen  <= (i_snap.len >= 16'(urcd_pkg::HDR_BYTES))
                           ? i_snap.len - 16'(urcd_pkg::HDR_BYTES) : 16'd0;
            end
        end
    end

    assign m_axis_tvalid = r_o_valid;
    // fields from bit 0: accepted, drop_reason[2:0], endpoint_index[2:0],
    // src_port, dst_port, payload_length, one pad bit
    assign m_axis_tdata  = {1'b0, r_plen, r_dport, r_sport, r_ep, r_rsn, r_acc};

    a_ep_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_rsn != urcd_pkg::RSN_OK |-> r_ep == 3'd0 && !r_acc)
        else $error("endpoint reported on dropped datagram");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && r_rsn == urcd_pkg::RSN_SHORT |-> r_sport == 16'd0 && r_dport == 16'd0
            && r_plen == 16'd0)
        else $error("short buffer carries header fields");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_plen <= 16'd65527)
        else $error("payload length out of range");

endmodule

[rtl/udp_receive_check_and_demux.sv]
// Top level: UDP receive check and port demux with port-slot configuration registers.
`timescale 1ns / 1ps

// Byte stream in on s_axis: one datagram byte per beat in tdata[7:0], with the
// IPv4 source and destination addresses in tdata[71:8] (read on the first byte
// of a datagram only) and tlast on the final byte of the buffer.
// One verdict beat per datagram comes out on m_axis after its tlast byte.
// The user writes port slots 0..7 through i_cfg_we / i_cfg_idx / i_cfg_data only
// while the block is idle, which it does not enforce; a zero slot never matches.
// A tlast beat passes the input register, the snapshot register and the result
// register, in that order, before its verdict shows on m_axis_tvalid.
// Throughput: one byte per cycle while m_axis drains; the running checksum and
// header capture are a combinational update of the registered datagram state,
// and the verdict is one pass of length compare, checksum fold and slot match.
// When m_axis_tready is low the result register holds; bytes keep flowing in
// while one more finished datagram waits in the snapshot register, and
// s_axis_tready drops only once a further tlast byte sits in the input register.
// Reset (synchronous, active low) empties the pipeline, clears all datagram
// state and clears every port slot to zero.
module udp_receive_check_and_demux (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // fields from bit 0: data_byte[7:0], src_ip[31:0], dst_ip[31:0]
    input  logic [urcd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // fields from bit 0: accepted, drop_reason[2:0], endpoint_index[2:0],
    // src_port, dst_port, payload_length, one pad bit
    output logic [urcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [urcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [urcd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    urcd_pkg::t_slots r_slots;
    urcd_pkg::t_snap  snap;
    logic             snap_valid;
    logic             snap_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= '0;
        end else if (i_cfg_we) begin
            r_slots[i_cfg_idx] <= i_cfg_data;
        end
    end

    urcd_accum u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_snap_take   (snap_take),
        .o_snap_valid  (snap_valid),
        .o_snap        (snap)
    );

    urcd_verdict u_verdict (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_snap_valid  (snap_valid),
        .i_snap        (snap),
        .i_slots       (r_slots),
        .o_snap_take   (snap_take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

[tb/tb_udp_receive_check_and_demux.sv]
// Self-checking testbench for the UDP receive check and port demux block.
`timescale 1ns / 1ps

module tb_udp_receive_check_and_demux;

    typedef enum {CK_GOOD, CK_ZERO, CK_BAD, CK_SLIP} t_ck_mode;

    typedef struct packed {
        logic              acc;
        urcd_pkg::t_reason reason;
        logic [2:0]        ep;
        logic [15:0]       sport;
        logic [15:0]       dport;
        logic [15:0]       plen;
    } t_verdict;

    localparam int DRAIN_LIMIT = 20000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [urcd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tlast = 1'b0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b1;
    logic [urcd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [urcd_pkg::CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [urcd_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_cnt = 0;

    // receive-side mirror of the block
    logic [15:0] slot_ports [urcd_pkg::SLOT_REGS];
    logic [15:0] rx_count, rx_sum, rx_len, rx_cks, rx_sport, rx_dport;
    logic [7:0]  rx_pend;
    logic [63:0] rx_addr;
    t_verdict    verdict_q[$];

    udp_receive_check_and_demux dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic void clear_rx();
        rx_count = '0;
        rx_sum   = '0;
        rx_pend  = '0;
        rx_len   = '0;
        rx_cks   = '0;
        rx_sport = '0;
        rx_dport = '0;
    endfunction

    // Fold one accepted byte into the mirror; queue a verdict on the last one.
    task automatic absorb_byte(input logic [7:0] b, input logic last,
                               input logic [31:0] src, input logic [31:0] dst);
        logic [15:0] idx;
        logic [16:0] total;
        logic [15:0] s, c;
        logic [7:0]  v;
        logic        found;
        t_verdict    vd;
        int          i;
        idx = rx_count;
        if (idx == 0)
            rx_addr = {src, dst};
        if (idx < 2)
            rx_sport = {rx_sport[7:0], b};
        else if (idx < 4)
            rx_dport = {rx_dport[7:0], b};
        else if (idx < 6)
            rx_len = {rx_len[7:0], b};
        else if (idx < 8)
            rx_cks = {rx_cks[7:0], b};
        if (idx < 8 || idx < rx_len) begin
            v = (idx == 6 || idx == 7) ? 8'h00 : b;
            if (!idx[0])
                rx_pend = v;
            else
                rx_sum = ones_add(rx_sum, {rx_pend, v});
        end
        total = {1'b0, idx} + 17'd1;
        if (rx_count != urcd_pkg::CNT_MAX)
            rx_count = rx_count + 16'd1;
        if (last) begin
            vd = '0;
            if (total < urcd_pkg::HDR_BYTES) begin
                vd.reason = urcd_pkg::RSN_SHORT;
            end else if (rx_len < urcd_pkg::HDR_BYTES || {1'b0, rx_len} > total) begin
                vd.reason = urcd_pkg::RSN_BAD_LEN;
            end else if (rx_cks != 0 && rx_len > urcd_pkg::MAX_PAYLOAD) begin
                vd.reason = urcd_pkg::RSN_TOO_LONG;
            end else begin
                vd.reason = urcd_pkg::RSN_OK;
                if (rx_cks != 0) begin
                    s = rx_sum;
                    if (rx_len[0])
                        s = ones_add(s, {rx_pend, 8'h00});
                    s = ones_add(s, rx_addr[63:48]);
                    s = ones_add(s, rx_addr[47:32]);
                    s = ones_add(s, rx_addr[31:16]);
                    s = ones_add(s, rx_addr[15:0]);
                    s = ones_add(s, urcd_pkg::PROTO_UDP);
                    s = ones_add(s, rx_len);
                    c = ~s;
                    // computed zero stands for a stored all-ones checksum
                    if (!(c == rx_cks || (c == 0 && rx_cks == 16'hFFFF)))
                        vd.reason = urcd_pkg::RSN_CKSUM;
                end
                if (vd.reason == urcd_pkg::RSN_OK) begin
                    found = 1'b0;
                    for (i = 0; i < urcd_pkg::PORT_SLOTS; i++) begin
                        if (!found && slot_ports[i] != 0 && slot_ports[i] == rx_dport) begin
                            found = 1'b1;
                            vd.ep = i[2:0];
                        end
                    end
                    vd.acc = found;
                    if (!found)
                        vd.reason = urcd_pkg::RSN_NO_PORT;
                end
            end
            if (vd.reason != urcd_pkg::RSN_SHORT) begin
                vd.sport = rx_sport;
                vd.dport = rx_dport;
                vd.plen  = (rx_len >= urcd_pkg::HDR_BYTES)
                           ? 16'(rx_len - urcd_pkg::HDR_BYTES) : 16'd0;
            end
            verdict_q.push_back(vd);
            clear_rx();
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : verdict_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("verdict beat with nothing expected: %h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = verdict_q.pop_front();
                check_field("accepted", 16'(want.acc), 16'(m_axis_tdata[0]));
                check_field("drop_reason", 16'(want.reason), 16'(m_axis_tdata[3:1]));
                check_field("endpoint_index", 16'(want.ep), 16'(m_axis_tdata[6:4]));
                check_field("src_port", want.sport, m_axis_tdata[22:7]);
                check_field("dst_port", want.dport, m_axis_tdata[38:23]);
                check_field("payload_length", want.plen, m_axis_tdata[54:39]);
            end
        end
    end

    // One byte beat; tasks start and end at a falling edge.
    task automatic push_byte(input logic [7:0] b, input logic last,
                             input logic [31:0] src, input logic [31:0] dst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src, b};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        absorb_byte(b, last, src, dst);
        @(negedge i_clk);
    endtask

    // Addresses only count on the first byte; later beats carry junk there.
    task automatic send_datagram(input logic [7:0] bq[$], input logic [31:0] src,
                                 input logic [31:0] dst);
        int i;
        for (i = 0; i < bq.size(); i++) begin
            if (i == 0)
                push_byte(bq[i], bq.size() == 1, src, dst);
            else
                push_byte(bq[i], i == bq.size() - 1, $urandom, $urandom);
        end
    endtask

    function automatic logic [15:0] udp_csum(input logic [7:0] bq[$], input logic [15:0] lf,
                                             input logic [31:0] src, input logic [31:0] dst);
        logic [31:0] acc;
        logic [7:0]  hi, lo;
        int          i, n;
        n = (lf < bq.size()) ? lf : bq.size();
        acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + urcd_pkg::PROTO_UDP + lf;
        for (i = 0; i < n; i += 2) begin
            hi = (i == 6) ? 8'h00 : bq[i];
            lo = (i + 1 < n && i + 1 != 7) ? bq[i + 1] : 8'h00;
            acc += {hi, lo};
        end
        while (acc[31:16] != 0)
            acc = acc[15:0] + acc[31:16];
        return ~acc[15:0];
    endfunction

    task automatic build_dgram(output logic [7:0] bq[$], input logic [15:0] sport,
                               input logic [15:0] dport, input int plen, input int extra,
                               input int len_f, input t_ck_mode mode,
                               input logic [31:0] src, input logic [31:0] dst);
        logic [15:0] lf, c;
        int          i;
        lf = 16'(len_f);
        bq = {};
        bq.push_back(sport[15:8]);
        bq.push_back(sport[7:0]);
        bq.push_back(dport[15:8]);
        bq.push_back(dport[7:0]);
        bq.push_back(lf[15:8]);
        bq.push_back(lf[7:0]);
        bq.push_back(8'h00);
        bq.push_back(8'h00);
        for (i = 0; i < plen + extra; i++)
            bq.push_back(8'($urandom));
        if (mode == CK_SLIP && plen >= 2) begin
            // first payload word cancels the rest: the sum folds to all ones
            bq[8] = 8'h00;
            bq[9] = 8'h00;
            c = udp_csum(bq, lf, src, dst);
            bq[8] = c[15:8];
            bq[9] = c[7:0];
        end
        c = udp_csum(bq, lf, src, dst);
        case (mode)
            CK_ZERO: c = 16'h0000;
            CK_BAD:  c = c ^ 16'(1 << $urandom_range(15));
            default: if (c == 0) c = 16'hFFFF;
        endcase
        bq[6] = c[15:8];
        bq[7] = c[7:0];
    endtask

    task automatic send_udp(input logic [15:0] sport, input logic [15:0] dport, input int plen,
                            input int extra, input int len_f, input t_ck_mode mode,
                            input logic [31:0] src, input logic [31:0] dst);
        logic [7:0] bq[$];
        build_dgram(bq, sport, dport, plen, extra, len_f, mode, src, dst);
        send_datagram(bq, src, dst);
    endtask

    task automatic send_short(input int n, input logic [31:0] src, input logic [31:0] dst);
        logic [7:0] bq[$];
        build_dgram(bq, rand16(), rand16(), 0, 0, 8, CK_GOOD, src, dst);
        while (bq.size() > n)
            void'(bq.pop_back());
        send_datagram(bq, src, dst);
    endtask

    task automatic drain_verdicts();
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0 && n < DRAIN_LIMIT) begin
            @(negedge i_clk);
            n++;
        end
        if (verdict_q.size() != 0) begin
            $error("%0d expected verdicts never arrived", verdict_q.size());
            err_cnt++;
            verdict_q.delete();
        end
        repeat (6) @(negedge i_clk);
    endtask

    task automatic load_slots(input logic [15:0] ports [urcd_pkg::SLOT_REGS]);
        int i;
        for (i = 0; i < urcd_pkg::SLOT_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= i[urcd_pkg::CFG_IDX_W-1:0];
            i_cfg_data <= ports[i];
            @(posedge i_clk);
            slot_ports[i] = ports[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Slots come out of reset empty, so nothing can match.
    task automatic test_empty_slots();
        send_udp(16'd1234, 16'd0, 4, 0, 12, CK_GOOD, $urandom, $urandom);
        send_udp(16'hFFFF, 16'hFFFF, 0, 0, 8, CK_ZERO, 32'h0, 32'h0);
        send_udp(rand16(), rand16(), 5, 0, 13, CK_GOOD, $urandom, $urandom);
        drain_verdicts();
    endtask

    task automatic test_header_cases();
        load_slots('{16'h0000, 16'hFFFF, 16'd7, 16'd7, 16'd1, 16'h8000, 16'd53, 16'h7FFF});
        send_short(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_short(7, $urandom, $urandom);
        send_udp(16'h0000, 16'hFFFF, 0, 0, 8, CK_GOOD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_udp(16'hFFFF, 16'd7, 3, 0, 11, CK_GOOD, 32'h0, 32'h0);
        send_udp(rand16(), 16'd1, 10, 0, 18, CK_ZERO, $urandom, $urandom);
        send_udp(rand16(), 16'd53, 10, 0, 18, CK_BAD, $urandom, $urandom);
        send_udp(rand16(), 16'h8000, 6, 0, 14, CK_SLIP, $urandom, $urandom);
        send_udp(rand16(), 16'h8000, 7, 0, 15, CK_SLIP, $urandom, $urandom);
        send_udp(rand16(), 16'd53, 4, 3, 12, CK_GOOD, $urandom, $urandom);
        send_udp(rand16(), 16'd7, 4, 0, 5, CK_GOOD, $urandom, $urandom);
        send_udp(rand16(), 16'd7, 4, 0, 0, CK_GOOD, $urandom, $urandom);
        send_udp(rand16(), 16'd7, 4, 0, 20, CK_GOOD, $urandom, $urandom);
        send_udp(rand16(), 16'd0, 2, 0, 10, CK_GOOD, $urandom, $urandom);
        send_udp(rand16(), 16'd9, 2, 0, 10, CK_GOOD, $urandom, $urandom);
        drain_verdicts();
    endtask

    task automatic test_random_traffic(input int min_bytes, input int min_dgrams);
        logic [15:0] ports [urcd_pkg::SLOT_REGS];
        logic [7:0]  bq[$];
        logic [31:0] src, dst;
        logic [15:0] dport;
        t_ck_mode    mode;
        int          i, k, plen, extra, len_f, cut, n_bytes, n_dgrams;
        for (i = 0; i < urcd_pkg::SLOT_REGS; i++)
            ports[i] = ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom);
        if ($urandom_range(1))
            ports[$urandom_range(7)] = ports[$urandom_range(7)];
        load_slots(ports);
        n_bytes = 0;
        n_dgrams = 0;
        while (n_bytes < min_bytes || n_dgrams < min_dgrams) begin
            src   = $urandom;
            dst   = $urandom;
            dport = ($urandom_range(9) < 7) ? slot_ports[$urandom_range(7)] : 16'($urandom);
            k     = $urandom_range(99);
            plen  = $urandom_range(24);
            extra = 0;
            cut   = 0;
            mode  = CK_GOOD;
            if (k >= 50 && k < 62)
                mode = CK_ZERO;
            else if (k >= 62 && k < 68) begin
                mode = CK_SLIP;
                plen = $urandom_range(2, 24);
            end else if (k >= 68 && k < 78)
                mode = CK_BAD;
            else if (k >= 78 && k < 84)
                extra = $urandom_range(1, 5);
            else if (k >= 84 && k < 89)
                cut = $urandom_range(1, 7);
            len_f = 8 + plen;
            if (k >= 89 && k < 94)
                len_f = $urandom_range(1) ? $urandom_range(7) : len_f + $urandom_range(1, 20);
            build_dgram(bq, rand16(), dport, plen, extra, len_f, mode, src, dst);
            if (cut != 0) begin
                while (bq.size() > cut)
                    void'(bq.pop_back());
            end
            if (k >= 94) begin
                // noise: no structure at all
                bq = {};
                repeat ($urandom_range(1, 30))
                    bq.push_back(8'($urandom));
            end
            send_datagram(bq, src, dst);
            n_bytes += bq.size();
            n_dgrams++;
        end
        drain_verdicts();
    endtask

    initial begin
        clear_rx();
        rx_addr = '0;
        for (int i = 0; i < urcd_pkg::SLOT_REGS; i++)
            slot_ports[i] = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 81;
        test_empty_slots();
        test_header_cases();
        test_random_traffic(180, 8);

        send_idle_pct = 81;
        recv_idle_pct = 30;
        test_random_traffic(180, 8);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(180, 8);

        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

[udp_receive_check_and_demux.f]
rtl/urcd_pkg.sv
rtl/urcd_accum.sv
rtl/urcd_verdict.sv
rtl/udp_receive_check_and_demux.sv
tb/tb_udp_receive_check_and_demux.sv
